// File: rtl/ox_pkg.sv
package ox_pkg;

	localparam int CITY_W    = 6;
	localparam int CFG_W     = 7;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;
	localparam int REG_IDX_W = 1;
	localparam int NUM_CODES = 1 << CITY_W;

	localparam logic [CFG_W-1:0]     NUM_CITIES_RST = 7'd64;
	localparam logic [REG_IDX_W-1:0] REG_NUM_CITIES = 1'b0;

	typedef struct packed {
		logic load;
		logic xo_init;
		logic copy;
		logic fill_init;
		logic fill;
		logic emit_init;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic run_end;
		logic copy_last;
		logic fill_last;
		logic emit_last;
	} sts_t;

endpackage

// File: rtl/ox_ram.sv
module ox_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ox_ctrl.sv
module ox_ctrl
	import ox_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_COPY   = 5'b00010,
		S_FILL   = 5'b00100,
		S_SETTLE = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start && sts.run_end) begin
					cmd.xo_init = 1'b1;
					state_d     = S_COPY;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					cmd.fill_init = 1'b1;
					state_d       = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				// let the last fill write land before reading the child back
				cmd.emit_init = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/ox_dp.sv
module ox_dp
	import ox_pkg::*;
#(
	parameter int MAX_CITIES = 64,
	localparam int AW = $clog2(MAX_CITIES),
	localparam int CNT_W = $clog2(MAX_CITIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [CNT_W-1:0]  n,
	input  logic [CITY_W-1:0] parent_a_city,
	input  logic [CITY_W-1:0] parent_b_city,
	input  logic [CITY_W-1:0] cut_a,
	input  logic [CITY_W-1:0] cut_b,
	output logic [CITY_W-1:0] child_city,
	output logic              last,
	output logic              valid
);

	logic [CNT_W-1:0]      load_cnt_q;
	logic [AW-1:0]         cut_lo_q, cut_hi_q;
	logic [AW-1:0]         idx_q, curr_q;
	logic [CNT_W-1:0]      step_q, placed_q;
	logic [NUM_CODES-1:0]  visited_q;
	logic [MAX_CITIES-1:0] cvalid_q;
	logic                  copy_s1, fill_s1, emit_s1;
	logic                  last_s1, cvld_s1;
	logic [AW-1:0]         widx_s1;
	logic                  valid_q, last_q;
	logic [CITY_W-1:0]     child_q;

	logic [CNT_W-1:0]  n_m1, load_nxt, need, hi_p1;
	logic [AW-1:0]     in_a, in_b, seg_lo, seg_hi, fill_start, idx_inc, curr_inc;
	logic [CITY_W-1:0] a_rd, b_rd, c_rd;
	logic              take;
	logic              c_we;
	logic [AW-1:0]     c_waddr;
	logic [CITY_W-1:0] c_wdata;

	function automatic logic [AW-1:0] sat_cut(input logic [CITY_W-1:0] c,
	                                          input logic [CNT_W-1:0] lim);
		if (CFG_W'(c) > CFG_W'(lim)) begin
			return AW'(lim);
		end
		return AW'(c);
	endfunction

	assign n_m1     = n - CNT_W'(1);
	assign load_nxt = load_cnt_q + CNT_W'(1);

	assign in_a   = sat_cut(cut_a, n_m1);
	assign in_b   = sat_cut(cut_b, n_m1);
	// count may have shrunk since the cuts were taken
	assign seg_lo = sat_cut(CITY_W'(cut_lo_q), n_m1);
	assign seg_hi = sat_cut(CITY_W'(cut_hi_q), n_m1);

	assign need       = n - CNT_W'(seg_hi - seg_lo) - CNT_W'(1);
	assign hi_p1      = CNT_W'(seg_hi) + CNT_W'(1);
	assign fill_start = (hi_p1 == n) ? '0 : AW'(hi_p1);
	assign idx_inc    = (CNT_W'(idx_q) + CNT_W'(1) == n) ? '0 : idx_q + AW'(1);
	assign curr_inc   = (CNT_W'(curr_q) + CNT_W'(1) == n) ? '0 : curr_q + AW'(1);

	assign sts.run_end   = (load_nxt >= n);
	assign sts.copy_last = (idx_q == seg_hi);
	assign sts.fill_last = (step_q == n_m1);
	assign sts.emit_last = (CNT_W'(idx_q) == n_m1);

	assign take = fill_s1 && !visited_q[b_rd] && (placed_q < need);

	assign c_we    = copy_s1 || take;
	assign c_waddr = copy_s1 ? widx_s1 : curr_q;
	assign c_wdata = copy_s1 ? a_rd : b_rd;

	ox_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_ram_a (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (AW'(load_cnt_q)),
		.wdata (parent_a_city),
		.raddr (idx_q),
		.rdata (a_rd)
	);

	ox_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_ram_b (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (AW'(load_cnt_q)),
		.wdata (parent_b_city),
		.raddr (idx_q),
		.rdata (b_rd)
	);

	ox_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_ram_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (idx_q),
		.rdata (c_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			cut_lo_q   <= '0;
			cut_hi_q   <= '0;
			idx_q      <= '0;
			curr_q     <= '0;
			step_q     <= '0;
			placed_q   <= '0;
			visited_q  <= '0;
			cvalid_q   <= '0;
			copy_s1    <= 1'b0;
			fill_s1    <= 1'b0;
			emit_s1    <= 1'b0;
			valid_q    <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				load_cnt_q <= sts.run_end ? '0 : load_nxt;
				if (load_cnt_q == '0) begin
					cut_lo_q <= (in_a <= in_b) ? in_a : in_b;
					cut_hi_q <= (in_a <= in_b) ? in_b : in_a;
				end
			end
			if (cmd.xo_init) begin
				idx_q     <= seg_lo;
				visited_q <= '0;
				cvalid_q  <= '0;
			end
			if (cmd.copy) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.fill_init) begin
				idx_q    <= fill_start;
				curr_q   <= fill_start;
				step_q   <= '0;
				placed_q <= '0;
			end
			if (cmd.fill) begin
				idx_q  <= idx_inc;
				step_q <= step_q + CNT_W'(1);
			end
			if (cmd.emit_init) begin
				idx_q <= '0;
			end
			if (cmd.emit) begin
				idx_q <= idx_q + AW'(1);
			end

			// stage 1: memory data is back
			if (copy_s1) begin
				cvalid_q[widx_s1] <= 1'b1;
				visited_q[a_rd]   <= 1'b1;
			end
			if (take) begin
				cvalid_q[curr_q] <= 1'b1;
				curr_q           <= curr_inc;
				placed_q         <= placed_q + CNT_W'(1);
			end

			copy_s1 <= cmd.copy;
			fill_s1 <= cmd.fill;
			emit_s1 <= cmd.emit;
			valid_q <= emit_s1;
			last_q  <= emit_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		widx_s1 <= idx_q;
		last_s1 <= sts.emit_last;
		cvld_s1 <= cvalid_q[idx_q];
		// positions never filled read as city zero
		child_q <= cvld_s1 ? c_rd : '0;
	end

	assign child_city = child_q;
	assign last       = last_q;
	assign valid      = valid_q;

endmodule

// File: rtl/order_crossover_permutation.sv
// Order crossover (OX) of two city permutations.
// Input channel: an item is taken on a clock edge with start high and busy
// low. Item k of a run carries city k of parent A and of parent B; the
// first item of a run also carries the two cut points. Items load at one
// per cycle into the parent memories.
// The item that completes a run (num_cities items) raises busy. The block
// then walks the segment (one parent A read per cycle), walks parent B
// once, waits in a settle state so the last fill write lands, and reads
// the child back. Each phase is paced by the single read port of each
// memory. Results: num_cities cities, one per cycle on child_city with
// valid high, last high on the final one; the first comes after the settle
// state, through the emit stage and the valid register. The receiver cannot
// stall: every result is shown for exactly one cycle.
// Configuration: num_cities at byte address 0 over the APB port; write it
// only while no run is in progress.
// Reset clears the run state and sets num_cities to 64; the memories hold
// no reset value and need no clearing pass.
module order_crossover_permutation
	import ox_pkg::*;
#(
	parameter int MAX_CITIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [CITY_W-1:0] parent_a_city,
	input  logic [CITY_W-1:0] parent_b_city,
	input  logic [CITY_W-1:0] cut_a,
	input  logic [CITY_W-1:0] cut_b,
	output logic [CITY_W-1:0] child_city,
	output logic              last,
	output logic              valid
);

	localparam int CNT_W = $clog2(MAX_CITIES + 1);

	logic [CFG_W-1:0] num_cities_q;
	logic [CNT_W-1:0] n_eff;
	logic             reg_hit;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_NUM_CITIES);
	assign prdata  = reg_hit ? APB_DW'(num_cities_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cities_q <= NUM_CITIES_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			num_cities_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		priority if (num_cities_q < CFG_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (num_cities_q > CFG_W'(MAX_CITIES)) begin
			n_eff = CNT_W'(MAX_CITIES);
		end else begin
			n_eff = CNT_W'(num_cities_q);
		end
	end

	ox_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ox_dp #(.MAX_CITIES(MAX_CITIES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.n             (n_eff),
		.parent_a_city (parent_a_city),
		.parent_b_city (parent_b_city),
		.cut_a         (cut_a),
		.cut_b         (cut_b),
		.child_city    (child_city),
		.last          (last),
		.valid         (valid)
	);

	a_busy_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

	a_last_marks_result: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> valid)
		else $error("last without a result");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("result right after the final city");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy, 2))
		else $error("result outside a crossover run");

endmodule
